// File: hdl/tcc_pkg.sv
// Shared constants, codes and interface types for the tuple coverage counter.
// No dependencies; imported by every module of the block.
package tcc_pkg;

    localparam int MAX_STRENGTH    = 6;
    localparam int STORE_BITS      = 65536;
    localparam int COVERAGE_LEVELS = 11;
    localparam int MAX_VALUES      = 64;

    localparam int NPOS    = 6;
    localparam int VAL_W   = 7;
    localparam int RADIX_W = 7;
    localparam int STR_W   = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 7;
    localparam int POS_W   = 3;
    localparam int CNT_W   = $clog2(STORE_BITS + 1);
    localparam int SPACE_W = 37;
    localparam int LEVEL_W = 4;
    localparam int STATUS_W = 2;
    localparam int LEVEL_TOP = COVERAGE_LEVELS - 1;

    localparam int INDEX_W   = $clog2(STORE_BITS);
    localparam int ROW_BITS  = (STORE_BITS >= 128) ? 64 : STORE_BITS / 2;
    localparam int BIT_W     = $clog2(ROW_BITS);
    localparam int ROWS      = (STORE_BITS + ROW_BITS - 1) / ROW_BITS;
    localparam int ROW_AW    = $clog2(ROWS);

    localparam logic [CFG_IDX_W-1:0] CFG_STRENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIX0   = 3'd1;

    localparam logic [STATUS_W-1:0] ST_MARKED   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DONTCARE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_SPACE    = 2'd3;

    typedef struct packed {
        logic [STR_W-1:0]                strength;
        logic [NPOS-1:0][RADIX_W-1:0]    radix;
        logic [SPACE_W-1:0]              space;
        logic                            space_big;
        logic                            busy;
    } cfg_t;

    typedef struct packed {
        logic                rd_en;
        logic                wr_en;
        logic [ROW_AW-1:0]   addr;
        logic [ROW_BITS-1:0] wdata;
    } mem_req_t;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] count;
    } lvl_req_t;

    typedef struct packed {
        logic               done;
        logic [LEVEL_W-1:0] level;
    } lvl_rsp_t;

endpackage

// File: hdl/tcc_bitmap.sv
// Covered-tuple bitmap store: single-port synchronous RAM, one row per access.
// Depends on tcc_pkg.
module tcc_bitmap import tcc_pkg::*; (
    input  logic                aclk,
    input  mem_req_t            req,
    output logic [ROW_BITS-1:0] rdata
);

    logic [ROW_BITS-1:0] mem [ROWS];
    logic [ROW_BITS-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd_en) begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/tcc_config.sv
// Configuration registers with saturation and iterative tuple-space product.
// Depends on tcc_pkg.
module tcc_config import tcc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    logic [STR_W-1:0]             strength_reg, strength_next;
    logic [NPOS-1:0][RADIX_W-1:0] radix_reg, radix_next;
    logic                         pend_reg, pend_next;
    logic                         run_reg, run_next;
    logic [POS_W-1:0]             step_reg, step_next;
    logic [SPACE_W-1:0]           acc_reg, acc_next;
    logic [SPACE_W-1:0]           space_reg, space_next;

    logic [STR_W-1:0]             strength_eff;
    logic [NPOS-1:0][RADIX_W-1:0] radix_eff;
    logic [RADIX_W-1:0]           factor;
    logic [SPACE_W+RADIX_W-1:0]   product;

    always_comb begin
        strength_eff = (strength_reg > STR_W'(MAX_STRENGTH)) ? STR_W'(MAX_STRENGTH)
                                                              : strength_reg;
        for (int i = 0; i < NPOS; i++) begin
            radix_eff[i] = (radix_reg[i] > RADIX_W'(MAX_VALUES)) ? RADIX_W'(MAX_VALUES)
                                                                  : radix_reg[i];
        end
        factor  = (step_reg < strength_eff) ? radix_eff[step_reg] : RADIX_W'(1);
        product = acc_reg * factor;
    end

    always_comb begin
        strength_next = strength_reg;
        radix_next    = radix_reg;
        pend_next     = pend_reg;
        run_next      = run_reg;
        step_next     = step_reg;
        acc_next      = acc_reg;
        space_next    = space_reg;

        if (run_reg) begin
            acc_next  = product[SPACE_W-1:0];
            step_next = step_reg + POS_W'(1);
            if (step_reg == POS_W'(NPOS - 1)) begin
                run_next   = 1'b0;
                space_next = product[SPACE_W-1:0];
            end
        end else if (pend_reg) begin
            pend_next = 1'b0;
            run_next  = 1'b1;
            step_next = '0;
            acc_next  = SPACE_W'(1);
        end

        if (cfg_wr_en) begin
            if (cfg_index == CFG_STRENGTH) begin
                strength_next = cfg_wdata[STR_W-1:0];
                pend_next     = 1'b1;
            end else if (cfg_index <= CFG_IDX_W'(NPOS)) begin
                radix_next[cfg_index - CFG_RADIX0] = cfg_wdata[RADIX_W-1:0];
                pend_next                          = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strength_reg <= STR_W'(2);
            for (int i = 0; i < NPOS; i++) begin
                radix_reg[i] <= RADIX_W'(2);
            end
            pend_reg  <= 1'b1;
            run_reg   <= 1'b0;
            step_reg  <= '0;
            space_reg <= SPACE_W'(4);
        end else begin
            strength_reg <= strength_next;
            radix_reg    <= radix_next;
            pend_reg     <= pend_next;
            run_reg      <= run_next;
            step_reg     <= step_next;
            space_reg    <= space_next;
        end
        acc_reg <= acc_next;
    end

    assign cfg.strength  = strength_eff;
    assign cfg.radix     = radix_eff;
    assign cfg.space     = space_reg;
    assign cfg.space_big = (space_reg > SPACE_W'(STORE_BITS));
    assign cfg.busy      = pend_reg | run_reg;

endmodule

// File: hdl/tcc_level.sv
// Coverage level unit: min(floor(top*count/space), top) by repeated add and compare.
// Depends on tcc_pkg.
module tcc_level import tcc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  lvl_req_t           req,
    input  logic [SPACE_W-1:0] space,
    output lvl_rsp_t           rsp
);

    localparam int ACC_W = SPACE_W + LEVEL_W;
    localparam int NUM_W = CNT_W + LEVEL_W;

    logic                run_reg, run_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [NUM_W-1:0]    num_reg, num_next;
    logic [LEVEL_W-1:0]  lvl_reg, lvl_next;
    logic                step_ok;

    assign step_ok = (acc_reg <= ACC_W'(num_reg)) && (lvl_reg < LEVEL_W'(LEVEL_TOP));

    always_comb begin
        run_next = run_reg;
        acc_next = acc_reg;
        num_next = num_reg;
        lvl_next = lvl_reg;
        if (req.start) begin
            run_next = 1'b1;
            acc_next = ACC_W'(space);
            num_next = NUM_W'(req.count * LEVEL_TOP);
            lvl_next = '0;
        end else if (run_reg) begin
            if (step_ok) begin
                lvl_next = lvl_reg + LEVEL_W'(1);
                acc_next = acc_reg + ACC_W'(space);
            end else begin
                run_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
        end else begin
            run_reg <= run_next;
        end
        acc_reg <= acc_next;
        num_reg <= num_next;
        lvl_reg <= lvl_next;
    end

    assign rsp.done  = run_reg & ~step_ok;
    assign rsp.level = lvl_reg;

endmodule

// File: hdl/tway_tuple_coverage_counter_unit.sv
// Tuple coverage counter: a result goes out after the digit scan (cut short when a digit
// stops it) and the bitmap read and modify, after the level unit on a last request with a
// nonzero tuple space, and after a clear sweep of all 1024 bitmap rows on a first request;
// one request in flight, the digit loop and the bitmap read-modify-write set the rate.
// Reset runs the clear sweep and a radix product over the six positions; a strength or
// radix write starts the product again.
module tway_tuple_coverage_counter_unit import tcc_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [VAL_W-1:0]    s_value_0,
    input  logic signed [VAL_W-1:0]    s_value_1,
    input  logic signed [VAL_W-1:0]    s_value_2,
    input  logic signed [VAL_W-1:0]    s_value_3,
    input  logic signed [VAL_W-1:0]    s_value_4,
    input  logic signed [VAL_W-1:0]    s_value_5,
    input  logic                       s_first_test,
    input  logic                       s_last_test,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_newly_covered,
    output logic [STATUS_W-1:0]        m_status,
    output logic [CNT_W-1:0]           m_covered_count,
    output logic [SPACE_W-1:0]         m_tuple_space,
    output logic [LEVEL_W-1:0]         m_coverage_level,
    output logic                       m_last,
    input  logic                       cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_wdata
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CLEAR  = 3'd1;
    localparam logic [2:0] S_DIGIT  = 3'd2;
    localparam logic [2:0] S_READ   = 3'd3;
    localparam logic [2:0] S_MODIFY = 3'd4;
    localparam logic [2:0] S_LEVEL  = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    cfg_t                cfg;
    mem_req_t            mem_req;
    logic [ROW_BITS-1:0] mem_rdata;
    lvl_req_t            lvl_req;
    lvl_rsp_t            lvl_rsp;

    logic [2:0]                 state_reg, state_next;
    logic [ROW_AW-1:0]          clr_row_reg, clr_row_next;
    logic                       item_reg, item_next;
    logic [NPOS-1:0][VAL_W-1:0] val_reg, val_next;
    logic                       last_reg, last_next;
    logic [POS_W-1:0]           digit_reg, digit_next;
    logic [INDEX_W-1:0]         idx_reg, idx_next;
    logic [STATUS_W-1:0]        status_reg, status_next;
    logic                       fresh_reg, fresh_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [LEVEL_W-1:0]         level_reg, level_next;

    logic                       m_valid_reg, m_valid_next;
    logic                       o_fresh_reg, o_fresh_next;
    logic [STATUS_W-1:0]        o_status_reg, o_status_next;
    logic [CNT_W-1:0]           o_cnt_reg, o_cnt_next;
    logic [SPACE_W-1:0]         o_space_reg, o_space_next;
    logic [LEVEL_W-1:0]         o_level_reg, o_level_next;
    logic                       o_last_reg, o_last_next;

    logic                       accept;
    logic [POS_W-1:0]           pos;
    logic [VAL_W-1:0]           cur_val;
    logic [RADIX_W-1:0]         cur_radix;
    logic [INDEX_W+RADIX_W-1:0] idx_prod;
    logic                       cur_bit;
    logic                       mark;

    tcc_config u_config (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tcc_bitmap u_bitmap (
        .aclk  (aclk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    tcc_level u_level (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (lvl_req),
        .space   (cfg.space),
        .rsp     (lvl_rsp)
    );

    assign s_ready   = (state_reg == S_IDLE) && !cfg.busy;
    assign accept    = s_valid && s_ready;
    assign pos       = (digit_reg < POS_W'(NPOS)) ? digit_reg : '0;
    assign cur_val   = val_reg[pos];
    assign cur_radix = cfg.radix[pos];
    assign idx_prod  = idx_reg * cur_radix;
    assign cur_bit   = mem_rdata[idx_reg[BIT_W-1:0]];
    assign mark      = (status_reg == ST_MARKED) && !cur_bit;

    always_comb begin
        state_next   = state_reg;
        clr_row_next = clr_row_reg;
        item_next    = item_reg;
        val_next     = val_reg;
        last_next    = last_reg;
        digit_next   = digit_reg;
        idx_next     = idx_reg;
        status_next  = status_reg;
        fresh_next   = fresh_reg;
        cnt_next     = cnt_reg;
        level_next   = level_reg;

        m_valid_next  = m_valid_reg & ~m_ready;
        o_fresh_next  = o_fresh_reg;
        o_status_next = o_status_reg;
        o_cnt_next    = o_cnt_reg;
        o_space_next  = o_space_reg;
        o_level_next  = o_level_reg;
        o_last_next   = o_last_reg;

        mem_req       = '0;
        lvl_req.start = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    item_next   = 1'b1;
                    val_next    = {s_value_5, s_value_4, s_value_3,
                                   s_value_2, s_value_1, s_value_0};
                    last_next   = s_last_test;
                    digit_next  = '0;
                    idx_next    = '0;
                    status_next = ST_MARKED;
                    fresh_next  = 1'b0;
                    level_next  = '0;
                    clr_row_next = '0;
                    state_next  = s_first_test ? S_CLEAR : S_DIGIT;
                end
            end
            S_CLEAR: begin
                mem_req.wr_en = 1'b1;
                mem_req.addr  = clr_row_reg;
                mem_req.wdata = '0;
                cnt_next      = '0;
                clr_row_next  = clr_row_reg + ROW_AW'(1);
                if (clr_row_reg == ROW_AW'(ROWS - 1)) begin
                    state_next = item_reg ? S_DIGIT : S_IDLE;
                end
            end
            S_DIGIT: begin
                if (cfg.space_big) begin
                    status_next = ST_SPACE;
                    state_next  = S_READ;
                end else if (digit_reg >= cfg.strength) begin
                    state_next = S_READ;
                end else if (cur_val[VAL_W-1]) begin
                    status_next = ST_DONTCARE;
                    state_next  = S_READ;
                end else if (cur_val >= cur_radix) begin
                    status_next = ST_RANGE;
                    state_next  = S_READ;
                end else begin
                    idx_next   = idx_prod[INDEX_W-1:0] + INDEX_W'(cur_val);
                    digit_next = digit_reg + POS_W'(1);
                end
            end
            S_READ: begin
                mem_req.rd_en = (status_reg == ST_MARKED);
                mem_req.addr  = idx_reg[INDEX_W-1:BIT_W];
                state_next    = S_MODIFY;
            end
            S_MODIFY: begin
                mem_req.addr = idx_reg[INDEX_W-1:BIT_W];
                if (mark) begin
                    mem_req.wr_en = 1'b1;
                    mem_req.wdata = mem_rdata | (ROW_BITS'(1) << idx_reg[BIT_W-1:0]);
                    cnt_next      = cnt_reg + CNT_W'(1);
                    fresh_next    = 1'b1;
                end
                if (last_reg && (cfg.space != '0)) begin
                    lvl_req.start = 1'b1;
                    state_next    = S_LEVEL;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_LEVEL: begin
                if (lvl_rsp.done) begin
                    level_next = lvl_rsp.level;
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    o_fresh_next  = fresh_reg;
                    o_status_next = status_reg;
                    o_cnt_next    = cnt_reg;
                    o_space_next  = cfg.space;
                    o_level_next  = level_reg;
                    o_last_next   = last_reg;
                    item_next     = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        lvl_req.count = cnt_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_row_reg <= '0;
            item_reg    <= 1'b0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_row_reg <= clr_row_next;
            item_reg    <= item_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
        val_reg      <= val_next;
        last_reg     <= last_next;
        digit_reg    <= digit_next;
        idx_reg      <= idx_next;
        status_reg   <= status_next;
        fresh_reg    <= fresh_next;
        level_reg    <= level_next;
        o_fresh_reg  <= o_fresh_next;
        o_status_reg <= o_status_next;
        o_cnt_reg    <= o_cnt_next;
        o_space_reg  <= o_space_next;
        o_level_reg  <= o_level_next;
        o_last_reg   <= o_last_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_newly_covered  = o_fresh_reg;
    assign m_status         = o_status_reg;
    assign m_covered_count  = o_cnt_reg;
    assign m_tuple_space    = o_space_reg;
    assign m_coverage_level = o_level_reg;
    assign m_last           = o_last_reg;

`ifndef SYNTHESIS
    a_mark_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MODIFY && mark) |=> (cnt_reg == $past(cnt_reg) + CNT_W'(1)))
        else $error("covered count not advanced on new tuple");

    a_fresh_is_marked: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_newly_covered) |-> (m_status == ST_MARKED))
        else $error("new tuple reported with non-marked status");

    a_no_accept_cfg_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg.busy |-> !s_ready)
        else $error("request accepted during tuple space update");

    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_coverage_level <= LEVEL_W'(LEVEL_TOP)))
        else $error("coverage level above top bucket");
`endif

endmodule
